// ===== rtl/small_register_machine_executor_assert.svh =====
// assertion macros for the register machine executor
`ifndef SMALL_REGISTER_MACHINE_EXECUTOR_ASSERT_SVH
`define SMALL_REGISTER_MACHINE_EXECUTOR_ASSERT_SVH

// same-cycle implication on the block clock
`define SRME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the block clock
`define SRME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srme_pkg.sv =====
`timescale 1ns / 1ps
package srme_pkg;

  // opcodes
  localparam logic [3:0] OP_MOV = 4'd1;
  localparam logic [3:0] OP_LDR = 4'd2;
  localparam logic [3:0] OP_STR = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_SUB = 4'd5;
  localparam logic [3:0] OP_MUL = 4'd6;
  localparam logic [3:0] OP_DIV = 4'd7;
  localparam logic [3:0] OP_CMP = 4'd8;
  localparam logic [3:0] OP_JEQ = 4'd10;
  localparam logic [3:0] OP_JLT = 4'd12;
  localparam logic [3:0] OP_JGT = 4'd14;

  // operand kinds
  localparam logic [1:0] KIND_IMM   = 2'd1;
  localparam logic [1:0] KIND_REG   = 2'd2;
  localparam logic [1:0] KIND_LABEL = 2'd3;

  // fault codes
  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_OPCODE = 2'd1;
  localparam logic [1:0] FAULT_LABEL  = 2'd2;

  // compare states
  localparam logic [1:0] CMP_NONE  = 2'd0;
  localparam logic [1:0] CMP_EQUAL = 2'd1;
  localparam logic [1:0] CMP_LESS  = 2'd2;
  localparam logic [1:0] CMP_MORE  = 2'd3;

  localparam int PtrW = 11;
  localparam int LenW = 17;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/srme_in_if.sv =====
`timescale 1ns / 1ps
interface srme_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [1:0]  first_kind;
  logic [31:0] first_value;
  logic [1:0]  second_kind;
  logic [31:0] second_value;
  logic [9:0]  jump_target;

  modport source (output valid, action, first_kind, first_value, second_kind,
                  second_value, jump_target, input ready);
  modport sink (input valid, action, first_kind, first_value, second_kind,
                second_value, jump_target, output ready);
endinterface

// ===== rtl/srme_out_if.sv =====
`timescale 1ns / 1ps
interface srme_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] next_pointer;
  logic        jump_taken;
  logic        halted;
  logic [1:0]  fault_code;
  logic [1:0]  compare_state;

  modport source (output valid, next_pointer, jump_taken, halted, fault_code,
                  compare_state, input ready);
  modport sink (input valid, next_pointer, jump_taken, halted, fault_code,
                compare_state, output ready);
endinterface

// ===== rtl/srme_div.sv =====
`timescale 1ns / 1ps
module srme_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           dividend_i,
  input  logic [31:0]           divisor_i,
  output srme_pkg::div_stat_t   stat_o,
  output logic [31:0]           quotient_o
);
  import srme_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== rtl/small_register_machine_executor.sv =====
`timescale 1ns / 1ps
// sequence: a result passes through READ and DONE; ldr adds LOAD (byte bank read),
//   div adds DIV (32 quotient steps, with the writeback as the divider finishes)
// flow: a new instruction is taken only in IDLE, once the last one is through; a full result
//   register holds the sequencer until the sink takes the waiting transfer
// reset: registers, pointer, compare state and halt clear at once, then the data memory
//   is swept to zero one row of four bytes per cycle, no input before
module small_register_machine_executor #(
  parameter int MEMORY_BYTES   = 1024,
  parameter int PROGRAM_DEPTH  = 1024,
  parameter int REGISTER_COUNT = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [srme_pkg::PtrW-1:0] cfg_wdata_i,
  srme_in_if.sink                in_ch,
  srme_out_if.source             out_ch
);
  import srme_pkg::*;

  `include "small_register_machine_executor_assert.svh"

  localparam int RIW  = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int AW   = $clog2(MEMORY_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = MEMORY_BYTES / 4;

  state_e state_q, state_d;

  // configuration and architectural state
  logic [PtrW-1:0] plen_q;
  logic [PtrW-1:0] ip_q, ip_d;
  logic [1:0]      cmp_q, cmp_d;
  logic            stop_q, stop_d;
  logic [LenW-1:0] eff_len;
  logic            active;

  // latched instruction
  logic [3:0]  op_q;
  logic [1:0]  k1_q, k2_q;
  logic [31:0] v1_q, v2_q;
  logic [9:0]  tgt_q;

  // register file memory
  logic [31:0]         rf_mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rvld_q;
  logic [31:0]         rda_q, rdb_q;
  logic                vla_q, vlb_q;
  logic [31:0]         ra_val, rb_val;
  logic                rf_we;
  logic [31:0]         rf_wdata;
  logic [RIW-1:0]      rf_waddr;

  // byte banks
  logic [7:0]    bank_mem [4][ROWS];
  logic [3:0]    bk_we;
  logic [RW-1:0] bk_row [4];
  logic [7:0]    bk_wdata [4];
  logic [7:0]    bk_rdata_q [4];
  logic [1:0]    off_q;
  logic [RW-1:0] clr_row_q;
  logic [31:0]   ld_word;

  // decode
  logic [31:0] a1, b2;
  logic        src_ok;
  logic [AW-1:0] maddr;
  logic        jmp_cond, is_jump;
  logic        jumped_d, jumped_q;
  logic [1:0]  fault_d, fault_q;

  // divider
  logic        div_start;
  div_stat_t   div_stat;
  logic [31:0] div_quo;

  // output register
  logic        out_load;
  logic        ovalid_q;

  assign eff_len = (LenW'(plen_q) < LenW'(PROGRAM_DEPTH)) ? LenW'(plen_q)
                                                          : LenW'(PROGRAM_DEPTH);
  assign active  = !stop_q && (LenW'(ip_q) < eff_len);

  // register read values, unwritten entries read as zero
  assign ra_val = vla_q ? rda_q : '0;
  assign rb_val = vlb_q ? rdb_q : '0;

  // operand decode and control flow of the current instruction
  always_comb begin
    a1 = (k1_q == KIND_IMM) ? v1_q : ((k1_q == KIND_REG) ? ra_val : '0);
    b2 = (k2_q == KIND_IMM) ? v2_q : ((k2_q == KIND_REG) ? rb_val : '0);
    src_ok = (k1_q == KIND_REG) && ((k2_q == KIND_IMM) || (k2_q == KIND_REG));
    maddr = (op_q == OP_LDR) ? (src_ok ? b2[AW-1:0] : '0) : b2[AW-1:0];
    is_jump  = 1'b0;
    jmp_cond = 1'b0;
    fault_d  = FAULT_NONE;
    jumped_d = 1'b0;
    cmp_d    = cmp_q;
    stop_d   = stop_q;
    ip_d     = ip_q;
    if (active) begin
      unique case (op_q)
        OP_MOV, OP_LDR, OP_STR, OP_ADD, OP_SUB, OP_MUL, OP_DIV: ;
        OP_CMP: cmp_d = (a1 == b2) ? CMP_EQUAL : ((a1 < b2) ? CMP_LESS : CMP_MORE);
        OP_JEQ: begin
          is_jump  = 1'b1;
          jmp_cond = (cmp_q == CMP_EQUAL);
        end
        OP_JLT: begin
          is_jump  = 1'b1;
          jmp_cond = (cmp_q == CMP_LESS);
        end
        OP_JGT: begin
          is_jump  = 1'b1;
          jmp_cond = (cmp_q == CMP_MORE);
        end
        default: begin
          fault_d = FAULT_OPCODE;
          stop_d  = 1'b1;
        end
      endcase
      if (is_jump && jmp_cond) begin
        if (k1_q == KIND_LABEL) begin
          jumped_d = 1'b1;
          ip_d     = {1'b0, tgt_q};
        end else begin
          fault_d = FAULT_LABEL;
        end
      end
      if ((fault_d != FAULT_OPCODE) && !jumped_d) begin
        ip_d = ip_q + PtrW'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_row_q == RW'(ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_d = ST_READ;
      ST_READ: begin
        state_d = ST_DONE;
        if (active && (op_q == OP_LDR)) begin
          state_d = ST_LOAD;
        end else if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_LOAD:  state_d = ST_DONE;
      ST_DIV:   if (div_stat.done) state_d = ST_DONE;
      ST_DONE:  if (!ovalid_q || out_ch.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // load word assembly, byte i comes from bank (offset + i)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_word[8*i +: 8] = bk_rdata_q[2'(int'(off_q) + i)];
    end
  end

  // control outputs of the sequencer
  always_comb begin
    in_ch.ready = (state_q == ST_IDLE);
    out_load    = (state_q == ST_DONE) && (!ovalid_q || out_ch.ready);
    div_start   = (state_q == ST_READ) && active && (op_q == OP_DIV) && src_ok &&
                  (b2 != '0);
    rf_waddr    = v1_q[RIW-1:0];
    rf_we       = 1'b0;
    rf_wdata    = '0;
    bk_we       = '0;
    for (int j = 0; j < 4; j++) begin
      bk_row[j]   = maddr[AW-1:2] + RW'(2'(j) < maddr[1:0]);
      bk_wdata[j] = a1[8*(2'(2'(j) - maddr[1:0])) +: 8];
    end
    unique case (state_q)
      ST_CLEAR: begin
        bk_we = 4'hf;
        for (int j = 0; j < 4; j++) begin
          bk_row[j]   = clr_row_q;
          bk_wdata[j] = '0;
        end
      end
      ST_READ: begin
        if (active) begin
          unique case (op_q)
            OP_MOV: begin
              rf_we    = src_ok;
              rf_wdata = b2;
            end
            OP_ADD: begin
              rf_we    = src_ok;
              rf_wdata = ra_val + b2;
            end
            OP_SUB: begin
              rf_we    = src_ok;
              rf_wdata = ra_val - b2;
            end
            OP_MUL: begin
              rf_we    = src_ok;
              rf_wdata = ra_val * b2;
            end
            OP_DIV: begin
              rf_we    = src_ok && (b2 == '0);
              rf_wdata = '1;
            end
            OP_STR: bk_we = 4'hf;
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        rf_we    = 1'b1;
        rf_wdata = ld_word;
      end
      ST_DIV: begin
        rf_we    = div_stat.done;
        rf_wdata = div_quo;
      end
      ST_IDLE, ST_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      plen_q    <= '0;
      ip_q      <= '0;
      cmp_q     <= CMP_NONE;
      stop_q    <= 1'b0;
      rvld_q    <= '0;
      clr_row_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        plen_q <= cfg_wdata_i;
      end
      if (state_q == ST_READ) begin
        ip_q   <= ip_d;
        cmp_q  <= cmp_d;
        stop_q <= stop_d;
      end
      if (rf_we) begin
        rvld_q[rf_waddr] <= 1'b1;
      end
      if (state_q == ST_CLEAR) begin
        clr_row_q <= clr_row_q + RW'(1);
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // instruction latch and step results
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      op_q  <= in_ch.action;
      k1_q  <= in_ch.first_kind;
      v1_q  <= in_ch.first_value;
      k2_q  <= in_ch.second_kind;
      v2_q  <= in_ch.second_value;
      tgt_q <= in_ch.jump_target;
    end
    if (state_q == ST_READ) begin
      jumped_q <= jumped_d;
      fault_q  <= fault_d;
      off_q    <= maddr[1:0];
    end
  end

  // register file memory, two registered read ports
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    rda_q <= rf_mem[in_ch.first_value[RIW-1:0]];
    rdb_q <= rf_mem[in_ch.second_value[RIW-1:0]];
    vla_q <= rvld_q[in_ch.first_value[RIW-1:0]];
    vlb_q <= rvld_q[in_ch.second_value[RIW-1:0]];
  end

  // four byte banks, one access each per cycle
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (bk_we[j]) begin
        bank_mem[j][bk_row[j]] <= bk_wdata[j];
      end
      bk_rdata_q[j] <= bank_mem[j][bk_row[j]];
    end
  end

  srme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ra_val),
    .divisor_i  (b2),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch.next_pointer  <= ip_q;
      out_ch.jump_taken    <= jumped_q;
      out_ch.halted        <= stop_q || (LenW'(ip_q) >= eff_len);
      out_ch.fault_code    <= fault_q;
      out_ch.compare_state <= cmp_q;
    end
  end

  assign out_ch.valid = ovalid_q;

  `SRME_ASSERT_NXT(a_accept_read, in_ch.valid && in_ch.ready, state_q == ST_READ, "no read after transfer")
  `SRME_ASSERT_IMP(a_out_from_done, $rose(ovalid_q), $past(state_q == ST_DONE), "result out of order")
  `SRME_ASSERT_IMP(a_div_in_read, div_start, state_q == ST_READ && !div_stat.busy, "bad divide start")
  `SRME_ASSERT_IMP(a_no_rf_clear, rf_we, state_q != ST_CLEAR && state_q != ST_IDLE, "stray write")

endmodule
